// File: sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants for the layer stack compositor
// Operation codes, field widths and slot record layout.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int unsigned NumLayers = 16;
  localparam int unsigned IdW       = $clog2(NumLayers);
  localparam int unsigned CntW      = $clog2(NumLayers + 1);

  typedef enum logic [2:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_SET_BUF = 3'd1,
    FUNC_SET_LVL = 3'd2,
    FUNC_SLIDE   = 3'd3,
    FUNC_FREE    = 3'd4,
    FUNC_RESOLVE = 3'd5
  } func_t;

  localparam logic [0:0] CFG_SCREEN_W = 1'b0;
  localparam logic [0:0] CFG_SCREEN_H = 1'b1;

  // geometry record of one slot, kept in RAM
  typedef struct packed {
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [11:0] size_w;
    logic [11:0] size_h;
    logic [31:0] base;
  } slot_rec_t;

  localparam int unsigned RecW = $bits(slot_rec_t);

endpackage

// File: sv/layer_stack_compositor_unit.sv
// ----------------------------------------------------------------------------
// layer_stack_compositor_unit: window layer table with z-ordered stack
// Layer table ops and top-down pixel resolve over a RAM-held slot table.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one request (func, layer_id, position, size, base, level).
//   Requests are taken one at a time. Each yields exactly one result on out_*.
//   cfg_* writes screen width (index 0) or height (index 1) while idle.
// Steps (request accepted to result valid):
//   alloc, set buffer, slide, unknown func, hide/free of hidden layer: decode only.
//   set level / free of shown layer: each stack entry above it is moved down;
//   when the layer goes back in, each entry at or above the target moves up.
//   set level of hidden layer: each entry at or above the target moves up.
//   resolve: computes the destination address, then scans shown levels from
//   the top via the single read port of the slot record RAM and the stack RAM.
// Reset clears used flags, levels and stack count; slot records read as zero
// until first written. Screen size resets to 320 x 200.
// The result sits in an output register; while out_stall is high it holds,
// the next request is still taken and worked on, and its result waits for the
// register to free up.
// ----------------------------------------------------------------------------
module layer_stack_compositor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_layer_id,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [11:0] in_size_w,
  input  logic [11:0] in_size_h,
  input  logic [31:0] in_base_addr,
  input  logic signed [5:0]  in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [3:0]  out_out_layer,
  output logic        out_hit,
  output logic [31:0] out_src_addr,
  output logic [23:0] out_dest_addr,
  output logic [4:0]  out_shown_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned IdW  = lsc_pkg::IdW;
  localparam int unsigned CntW = lsc_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RM_RD, S_RM_WR, S_INS_RD, S_INS_WR, S_INS_PUT,
    S_RS_STK, S_RS_REC, S_RS_CHK, S_RS_MUL, S_DONE
  } state_t;

  state_t state_r;

  logic [11:0] scr_w_r, scr_h_r;

  // per-slot control state in flops (16 entries)
  logic [lsc_pkg::NumLayers-1:0] used_r;
  logic [lsc_pkg::NumLayers-1:0] rec_ok_r;   // record written since reset
  logic [lsc_pkg::NumLayers-1:0] shown_r;
  logic [CntW-1:0]               lvl_r [lsc_pkg::NumLayers];
  logic [CntW-1:0]               total_r;

  // latched request
  logic [2:0]  func_r;
  logic [IdW-1:0] id_r;
  logic signed [11:0] px_r, py_r;
  logic [11:0] sw_r, sh_r;
  logic [31:0] base_r;
  logic signed [5:0] req_r;

  logic [CntW-1:0] idx_r, tgt_r;
  logic            ins_r;   // insert pending after removal
  logic            onscr_r;

  // result
  logic        status_r, hit_r;
  logic [3:0]  layer_r;
  logic [31:0] src_r;
  logic [23:0] dest_r;

  // RAMs
  logic               stk_we, rec_we;
  logic [IdW-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic [IdW-1:0]     rec_waddr, rec_raddr;
  lsc_pkg::slot_rec_t rec_wdata, rec_rdata_raw, rec_rdata;
  logic [IdW-1:0]     rec_sel_r;

  lsc_ram #(.Width(IdW), .Depth(lsc_pkg::NumLayers)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  lsc_ram #(.Width(lsc_pkg::RecW), .Depth(lsc_pkg::NumLayers)) u_rec (
    .clk, .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata_raw));

  assign rec_rdata = rec_ok_r[rec_sel_r] ? rec_rdata_raw : '0;

  logic [IdW-1:0] stk_hold_r;
  logic signed [12:0] cx, cy;

  // pixel offset inside the layer being checked
  assign cx = 13'(px_r) - 13'(signed'(rec_rdata.pos_x));
  assign cy = 13'(py_r) - 13'(signed'(rec_rdata.pos_y));

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !out_valid;

  // record merge for set buffer / slide
  always_comb begin
    rec_wdata = rec_rdata;
    if (func_r == lsc_pkg::FUNC_SET_BUF) begin
      rec_wdata.size_w = sw_r;
      rec_wdata.size_h = sh_r;
      rec_wdata.base   = base_r;
    end else begin
      rec_wdata.pos_x = px_r;
      rec_wdata.pos_y = py_r;
    end
  end

  logic [IdW-1:0] free_id;
  logic           free_any;
  always_comb begin
    free_id  = '0;
    free_any = 1'b0;
    for (int i = lsc_pkg::NumLayers - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_id  = IdW'(i);
        free_any = 1'b1;
      end
    end
  end

  // clamp of requested level
  logic [CntW-1:0] top_lim, req_cl;
  logic            req_neg;
  always_comb begin
    top_lim = shown_r[id_r] ? total_r - CntW'(1) : total_r;
    req_neg = req_r[5];
    if (!req_neg && ($unsigned(req_r) > 6'(top_lim))) req_cl = top_lim;
    else req_cl = CntW'($unsigned(req_r[4:0]));
  end

  logic valid_op;
  assign valid_op = used_r[id_r];

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = idx_r[IdW-1:0];
    stk_wdata = stk_rdata;
    stk_raddr = idx_r[IdW-1:0];
    rec_we    = 1'b0;
    rec_waddr = id_r;
    rec_raddr = id_r;
    unique case (state_r)
      S_IDLE:    rec_raddr = in_layer_id;
      S_RM_RD:   stk_raddr = IdW'(idx_r + CntW'(1));
      S_RM_WR:   stk_we = 1'b1;
      S_INS_RD:  stk_raddr = IdW'(idx_r - CntW'(1));
      S_INS_WR:  stk_we = 1'b1;
      S_INS_PUT: begin
        stk_we    = 1'b1;
        stk_waddr = tgt_r[IdW-1:0];
        stk_wdata = id_r;
      end
      S_RS_STK:  stk_raddr = IdW'(idx_r - CntW'(1));
      S_RS_REC:  rec_raddr = stk_rdata;
      S_DEC: rec_we = valid_op && (func_r == lsc_pkg::FUNC_SET_BUF ||
                                   func_r == lsc_pkg::FUNC_SLIDE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      scr_w_r   <= 12'd320;
      scr_h_r   <= 12'd200;
      used_r    <= '0;
      rec_ok_r  <= '0;
      shown_r   <= '0;
      total_r   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < lsc_pkg::NumLayers; i++) lvl_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lsc_pkg::CFG_SCREEN_W) scr_w_r <= cfg_data;
        else scr_h_r <= cfg_data;
      end
      if (out_valid && !out_stall && state_r != S_DONE) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_func; id_r <= in_layer_id;
            px_r <= in_pos_x; py_r <= in_pos_y;
            sw_r <= in_size_w; sh_r <= in_size_h;
            base_r <= in_base_addr; req_r <= in_level;
            rec_sel_r <= in_layer_id;
            status_r <= 1'b0; hit_r <= 1'b0; layer_r <= '0;
            src_r <= '0; dest_r <= '0;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          case (func_r) inside
            lsc_pkg::FUNC_ALLOC: begin
              status_r <= !free_any;
              if (free_any) begin
                used_r[free_id] <= 1'b1;
                layer_r <= free_id;
              end
              state_r <= S_DONE;
            end
            lsc_pkg::FUNC_SET_BUF, lsc_pkg::FUNC_SLIDE: begin
              if (valid_op) rec_ok_r[id_r] <= 1'b1;
              state_r <= S_DONE;
            end
            lsc_pkg::FUNC_SET_LVL, lsc_pkg::FUNC_FREE: begin
              if (valid_op) begin
                if (func_r == lsc_pkg::FUNC_FREE) begin
                  used_r[id_r] <= 1'b0;
                  tgt_r <= '0;
                  ins_r <= 1'b0;
                end else begin
                  tgt_r <= req_cl;
                  ins_r <= !req_neg;
                end
                if (shown_r[id_r]) begin
                  idx_r   <= lvl_r[id_r];
                  state_r <= S_RM_RD;
                end else if (func_r == lsc_pkg::FUNC_SET_LVL && !req_neg) begin
                  idx_r   <= total_r;
                  state_r <= S_INS_RD;
                end else state_r <= S_DONE;
              end else state_r <= S_DONE;
            end
            lsc_pkg::FUNC_RESOLVE: begin
              onscr_r <= !px_r[11] && !py_r[11] && (12'(px_r) < scr_w_r) &&
                         (12'(py_r) < scr_h_r);
              idx_r   <= total_r;
              state_r <= S_RS_MUL;
            end
            default: state_r <= S_DONE;
          endcase
        end
        // remove: shift entries above down by one
        S_RM_RD: begin
          if (idx_r + CntW'(1) >= total_r) begin
            shown_r[id_r] <= 1'b0;
            total_r <= total_r - CntW'(1);
            if (ins_r) begin
              idx_r   <= total_r - CntW'(1);
              state_r <= S_INS_RD;
            end else state_r <= S_DONE;
          end else state_r <= S_RM_WR;
        end
        S_RM_WR: begin
          lvl_r[stk_rdata] <= idx_r;
          idx_r   <= idx_r + CntW'(1);
          state_r <= S_RM_RD;
        end
        // insert: shift entries at or above target up by one
        S_INS_RD: begin
          if (idx_r <= tgt_r) state_r <= S_INS_PUT;
          else state_r <= S_INS_WR;
        end
        S_INS_WR: begin
          lvl_r[stk_rdata] <= idx_r;
          idx_r   <= idx_r - CntW'(1);
          state_r <= S_INS_RD;
        end
        S_INS_PUT: begin
          shown_r[id_r] <= 1'b1;
          lvl_r[id_r]   <= tgt_r;
          total_r <= total_r + CntW'(1);
          state_r <= S_DONE;
        end
        S_RS_MUL: begin
          dest_r  <= onscr_r ? 24'(32'(py_r[10:0]) * 32'(scr_w_r) + 32'(px_r[10:0]))
                             : '0;
          state_r <= (onscr_r && idx_r != '0) ? S_RS_STK : S_DONE;
        end
        S_RS_STK: state_r <= S_RS_REC;
        S_RS_REC: begin
          rec_sel_r  <= stk_rdata;
          stk_hold_r <= stk_rdata;
          state_r    <= S_RS_CHK;
        end
        S_RS_CHK: begin
          if (!cx[12] && !cy[12] && (cx[11:0] < rec_rdata.size_w) &&
              (cy[11:0] < rec_rdata.size_h)) begin
            hit_r   <= 1'b1;
            layer_r <= stk_hold_r;
            src_r   <= rec_rdata.base + 32'(cy[11:0]) * 32'(rec_rdata.size_w) +
                       32'(cx[11:0]);
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r - CntW'(1);
            state_r <= (idx_r == CntW'(1)) ? S_DONE : S_RS_STK;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            out_status      <= status_r;
            out_out_layer   <= layer_r;
            out_hit         <= hit_r;
            out_src_addr    <= src_r;
            out_dest_addr   <= dest_r;
            out_shown_count <= total_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CntW'(lsc_pkg::NumLayers)) else $error("stack count overflow");
  a_shown_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (shown_r & ~used_r) == '0)
    else $error("shown slot not in use");
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> $countones(shown_r) == 32'(total_r))
    else $error("stack count mismatch");

endmodule

// File: sv/lsc_ram.sv
// ----------------------------------------------------------------------------
// lsc_ram: generic single-port-write, single-port-read RAM
// Registered read; rdata follows raddr in the next cycle.
// ----------------------------------------------------------------------------
module lsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for layer_stack_compositor_unit
// Drives table and resolve requests with random gaps, predicts every result
// from a behavioral copy of the layer table and stack, checks each field.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [2:0]         func;
    logic [3:0]         id;
    logic signed [11:0] px;
    logic signed [11:0] py;
    logic [11:0]        sw;
    logic [11:0]        sh;
    logic [31:0]        base;
    logic signed [5:0]  lvl;
  } req_t;

  typedef struct {
    logic        status;
    logic [3:0]  layer;
    logic        hit;
    logic [31:0] src;
    logic [23:0] dest;
    logic [4:0]  shown;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic [3:0] in_layer_id = '0;
  logic signed [11:0] in_pos_x = '0;
  logic signed [11:0] in_pos_y = '0;
  logic [11:0] in_size_w = '0;
  logic [11:0] in_size_h = '0;
  logic [31:0] in_base_addr = '0;
  logic signed [5:0] in_level = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_status;
  logic [3:0] out_out_layer;
  logic out_hit;
  logic [31:0] out_src_addr;
  logic [23:0] out_dest_addr;
  logic [4:0] out_shown_count;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [11:0] cfg_data = '0;

  layer_stack_compositor_unit dut (.*);

  initial forever #4 clk = ~clk;

  // predicted state
  int scr_w, scr_h;
  int order[16];
  int shown;
  bit used[16];
  int lvl_of[16];
  int lx[16], ly[16], lw[16], lh[16];
  logic [31:0] lbase[16];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int errors = 0;
  bit hold_send = 0;
  int send_gap = 0;
  int stall_gap = 0;
  longint cycles = 0;

  function automatic void restack(int id, int req);
    int old, top, i;
    old = lvl_of[id];
    top = shown - (old >= 0 ? 1 : 0);
    if (req > top) req = top;
    if (req < -1) req = -1;
    if (old >= 0) begin
      for (i = old; i + 1 < shown; i++) order[i] = order[i + 1];
      shown--;
      lvl_of[id] = -1;
    end
    if (req >= 0 && shown < 16) begin
      for (i = shown; i > req; i--) order[i] = order[i - 1];
      order[req] = id;
      shown++;
    end
    for (i = 0; i < shown; i++) lvl_of[order[i]] = i;
  endfunction

  function automatic res_t compose_result(req_t r);
    res_t o;
    int i, s, cx, cy, x, y;
    bit ok;
    o = '{default: '0};
    ok = used[r.id];
    x = r.px;
    y = r.py;
    case (r.func)
      lsc_pkg::FUNC_ALLOC: begin
        o.status = 1;
        for (i = 0; i < 16; i++)
          if (!used[i]) begin
            used[i] = 1; lvl_of[i] = -1; o.layer = 4'(i); o.status = 0;
            break;
          end
      end
      lsc_pkg::FUNC_SET_BUF: if (ok) begin
        lw[r.id] = int'(r.sw); lh[r.id] = int'(r.sh); lbase[r.id] = r.base;
      end
      lsc_pkg::FUNC_SET_LVL: if (ok) restack(int'(r.id), int'(r.lvl));
      lsc_pkg::FUNC_SLIDE: if (ok) begin
        lx[r.id] = x; ly[r.id] = y;
      end
      lsc_pkg::FUNC_FREE: if (ok) begin
        if (lvl_of[r.id] >= 0) restack(int'(r.id), -1);
        used[r.id] = 0;
      end
      lsc_pkg::FUNC_RESOLVE: if (x >= 0 && y >= 0 && x < scr_w && y < scr_h) begin
        o.dest = 24'(y * scr_w + x);
        for (i = shown; i > 0; i--) begin
          s = order[i - 1];
          cx = x - lx[s];
          cy = y - ly[s];
          if (cx >= 0 && cy >= 0 && cx < lw[s] && cy < lh[s]) begin
            o.hit = 1; o.layer = 4'(s);
            o.src = lbase[s] + 32'(cy) * 32'(lw[s]) + 32'(cx);
            break;
          end
        end
      end
      default: ;
    endcase
    o.shown = 5'(shown);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_results.push_back(compose_result(pending_reqs.pop_front()));
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0 || hold_send || pending_reqs.size() == 0 ||
            (in_valid && !in_stall && pending_reqs.size() == 0)) begin
          in_valid <= 0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          in_valid <= 1;
          in_func <= pending_reqs[0].func;
          in_layer_id <= pending_reqs[0].id;
          in_pos_x <= pending_reqs[0].px;
          in_pos_y <= pending_reqs[0].py;
          in_size_w <= pending_reqs[0].sw;
          in_size_h <= pending_reqs[0].sh;
          in_base_addr <= pending_reqs[0].base;
          in_level <= pending_reqs[0].lvl;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9));
        end
      end
    end
  end

  // Note: the popped head is the request just accepted; head of queue is next.
  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result layer=%0d", $time, out_out_layer);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if ({out_status, out_out_layer, out_hit, out_src_addr, out_dest_addr,
               out_shown_count} !== {e.status, e.layer, e.hit, e.src, e.dest, e.shown}) begin
            $display("%0t: mismatch exp st=%0d ly=%0d hit=%0d src=%h dst=%h cnt=%0d",
                     $time, e.status, e.layer, e.hit, e.src, e.dest, e.shown);
            $display("%0t:          act st=%0d ly=%0d hit=%0d src=%h dst=%h cnt=%0d",
                     $time, out_status, out_out_layer, out_hit, out_src_addr,
                     out_dest_addr, out_shown_count);
            errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        out_stall <= 1;
        stall_gap <= stall_gap - 1;
      end else if (out_valid && !out_stall) begin
        out_stall <= 0;
        stall_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9));
      end else out_stall <= 0;
    end
  end

  function automatic req_t mk_req(logic [2:0] f, int id, int x, int y, int w, int h,
                                  logic [31:0] b, int l);
    req_t r;
    r.func = f; r.id = 4'(id); r.px = 12'(x); r.py = 12'(y); r.sw = 12'(w);
    r.sh = 12'(h); r.base = b; r.lvl = 6'(l);
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    r.func = lsc_pkg::FUNC_RESOLVE;
    r.id = 4'($urandom_range(0, 15));
    r.px = 12'($urandom); r.py = 12'($urandom);
    r.sw = 12'($urandom); r.sh = 12'($urandom);
    r.base = $urandom;
    r.lvl = 6'($urandom);
    k = int'($urandom_range(0, 99));
    if (k < 8) r.func = lsc_pkg::FUNC_ALLOC;
    else if (k < 18) begin
      r.func = lsc_pkg::FUNC_SET_BUF;
      if (k < 16) begin
        r.sw = 12'($urandom_range(0, 120)); r.sh = 12'($urandom_range(0, 90));
      end
    end else if (k < 33) begin
      r.func = lsc_pkg::FUNC_SET_LVL;
      if (k < 30) r.lvl = 6'(int'($urandom_range(0, 18)) - 1);
    end else if (k < 43) begin
      r.func = lsc_pkg::FUNC_SLIDE;
      if (k < 40) begin
        r.px = 12'(int'($urandom_range(0, 200)) - 40);
        r.py = 12'(int'($urandom_range(0, 140)) - 30);
      end
    end else if (k < 48) r.func = lsc_pkg::FUNC_FREE;
    else if (k < 50) r.func = 3'($urandom_range(6, 7));
    else if (k < 95) begin
      r.px = 12'(int'($urandom_range(0, 170)) - 5);
      r.py = 12'(int'($urandom_range(0, 110)) - 5);
    end
    return r;
  endfunction

  task automatic drain();
    int n;
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    for (n = 0; n < 200; n++) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= 12'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == lsc_pkg::CFG_SCREEN_W) scr_w = v; else scr_h = v;
    @(posedge clk);
  endtask

  initial begin
    int i, ph;
    scr_w = 320; scr_h = 200; shown = 0;
    for (i = 0; i < 16; i++) begin
      used[i] = 0; lvl_of[i] = -1; lx[i] = 0; ly[i] = 0; lw[i] = 0; lh[i] = 0;
      lbase[i] = 0; order[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: resolve on empty stack, allocs, ops on unused slot, extremes
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_RESOLVE, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_LVL, 9, 0, 0, 0, 0, 0, 3));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_BUF, 0, 0, 0, 4095, 4095,
                                  32'hFFFF_FFF0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_BUF, 1, 0, 0, 10, 0, 32'h100, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SLIDE, 0, -2048, -2048, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_LVL, 0, 0, 0, 0, 0, 0, 31));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_LVL, 1, 0, 0, 0, 0, 0, -32));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_LVL, 1, 0, 0, 0, 0, 0, 16));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_RESOLVE, 0, 319, 199, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_RESOLVE, 0, 320, 5, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_RESOLVE, 0, -1, 5, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_RESOLVE, 0, 2047, 2047, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_SET_LVL, 0, 0, 0, 0, 0, 0, -1));
    pending_reqs.push_back(mk_req(3'd6, 3, 1, 1, 1, 1, 1, 1));
    pending_reqs.push_back(mk_req(3'd7, 15, -1, -1, 4095, 4095, '1, -1));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_FREE, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    for (i = 0; i < 15; i++)
      pending_reqs.push_back(mk_req(lsc_pkg::FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(lsc_pkg::FUNC_FREE, 15, 0, 0, 0, 0, 0, 0));
    for (i = 0; i < 60; i++) pending_reqs.push_back(rand_req());
    // sender holds off until every result is in
    while (pending_reqs.size() != 0) @(posedge clk);
    hold_send = 1;
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    hold_send = 0;
    for (ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(lsc_pkg::CFG_SCREEN_W, 1); write_reg(lsc_pkg::CFG_SCREEN_H, 1); end
        1: begin
          write_reg(lsc_pkg::CFG_SCREEN_W, 4095); write_reg(lsc_pkg::CFG_SCREEN_H, 4095);
        end
        2: begin write_reg(lsc_pkg::CFG_SCREEN_W, 0); write_reg(lsc_pkg::CFG_SCREEN_H, 37); end
        3: begin
          write_reg(lsc_pkg::CFG_SCREEN_W, 150); write_reg(lsc_pkg::CFG_SCREEN_H, 100);
        end
        default: begin
          write_reg(lsc_pkg::CFG_SCREEN_W, 2000); write_reg(lsc_pkg::CFG_SCREEN_H, 1);
        end
      endcase
      for (i = 0; i < 130; i++) pending_reqs.push_back(rand_req());
    end
    drain();
    if (errors == 0) $display("layer_stack_compositor_unit verification clean");
    else $display("layer_stack_compositor_unit verification failed");
    $finish;
  end

  initial begin
    wait (cycles > 400000);
    $display("layer_stack_compositor_unit verification failed");
    $finish;
  end

endmodule
